// ===== rtl/ase_pkg.sv =====
// Shared types, constants and helpers of the ARM-state execute unit.
package ase_pkg;

  // Register file: R0..R14 unbanked, then svc R13/R14, irq R13/R14 (slot 15 unused).
  localparam int RF_DEPTH = 20;
  localparam int RF_AW    = $clog2(RF_DEPTH);

  localparam logic [RF_AW-1:0] SLOT_SVC_SP = RF_AW'(16);
  localparam logic [RF_AW-1:0] SLOT_IRQ_SP = RF_AW'(18);

  localparam logic [3:0] MODE_SVC = 4'h3;
  localparam logic [3:0] MODE_IRQ = 4'h2;
  localparam logic [3:0] REG_PC   = 4'd15;
  localparam logic [3:0] REG_SP   = 4'd13;
  localparam logic [3:0] REG_LR   = 4'd14;

  localparam int T_BIT = 5;

  localparam logic [31:0] BX_MASK     = 32'h0FFF_FFF0;
  localparam logic [31:0] BX_PATTERN  = 32'h012F_FF10;
  localparam logic [5:0]  PSR_MRS     = 6'b001111;
  localparam logic [5:0]  PSR_MSR_ALL = 6'b101001;
  localparam logic [5:0]  PSR_MSR_FLG = 6'b101000;
  localparam logic [31:0] FLAG_MASK   = 32'hF000_0000;

  localparam logic [31:0] CPSR_COLD   = 32'h0000_0013;
  localparam logic [31:0] CPSR_BOOT   = 32'h0000_001F;
  localparam logic [31:0] BOOT_PC     = 32'h0800_0000;
  localparam logic [31:0] BOOT_SP     = 32'h0300_7F00;
  localparam logic [31:0] BOOT_SP_SVC = 32'h0300_7FE0;
  localparam logic [31:0] BOOT_SP_IRQ = 32'h0300_7FA0;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNSUP  = 2'd1,
    ST_UNDEF  = 2'd2,
    ST_PSR    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC,
    OP_TST, OP_TEQ, OP_CMP, OP_CMN, OP_ORR, OP_MOV, OP_BIC, OP_MVN
  } alu_op_t;

  typedef enum logic [1:0] {
    CLS_DP  = 2'd0,
    CLS_LS  = 2'd1,
    CLS_BR  = 2'd2,
    CLS_CP  = 2'd3
  } iclass_t;

  // Map a logical register index to its slot for the given mode.
  function automatic logic [RF_AW-1:0] phys_addr(input logic [3:0] idx, input logic [3:0] mode);
    logic [RF_AW-1:0] a;
    a = RF_AW'(idx);
    if ((idx == REG_SP) || (idx == REG_LR)) begin
      if (mode == MODE_SVC) begin
        a = SLOT_SVC_SP + RF_AW'(idx - REG_SP);
      end else if (mode == MODE_IRQ) begin
        a = SLOT_IRQ_SP + RF_AW'(idx - REG_SP);
      end
    end
    return a;
  endfunction

  // Value of a slot right after reset.
  function automatic logic [31:0] rf_reset_val(input logic [RF_AW-1:0] a, input logic boot);
    logic [31:0] v;
    v = 32'd0;
    if (boot) begin
      if (a == RF_AW'(REG_SP)) begin
        v = BOOT_SP;
      end else if (a == SLOT_SVC_SP) begin
        v = BOOT_SP_SVC;
      end else if (a == SLOT_IRQ_SP) begin
        v = BOOT_SP_IRQ;
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/ase_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ase_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = ase_pkg::RF_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/arm_state_execute_unit.sv =====
// Top level of the ARM-state execute unit: register file RAMs, execute stage, result register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  input    | in_valid / in_ready    | instr_word
//  result   | out_valid / out_ready  | executed, reg_written, dest_index, write_value,
//           |                        | branch_taken, next_fetch_addr, thumb_state,
//           |                        | flags_nzcv, status
//  config   | cfg_wr_en              | cfg_wr_data (direct_boot)
//
// One item per cycle while neither the result side nor a pending mode change holds the
// input: the register file is read at accept, the item then executes and its result is
// registered in the output register. An item that may change the mode (S with Rd = R15,
// or no S in opcode group 1001/1011, which holds MSR and BX) holds off the next accept
// until it leaves execute, since the bank of R13/R14 for the following read depends on it.
// Reset and a configuration write reload all state at once; unwritten register slots
// read as their reset value through per-slot valid bits. A stalled result register
// holds the execute stage, which holds the input.
module arm_state_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        executed,
  output logic        reg_written,
  output logic [3:0]  dest_index,
  output logic [31:0] write_value,
  output logic        branch_taken,
  output logic [31:0] next_fetch_addr,
  output logic        thumb_state,
  output logic [3:0]  flags_nzcv,
  output logic [1:0]  status
);

  localparam int AW = ase_pkg::RF_AW;

  // Architectural state kept in flops: PC, status words, boot select.
  logic        direct_boot;
  logic [31:0] pc;
  logic [31:0] cpsr;
  logic [31:0] saved_svc;
  logic [31:0] saved_irq;
  logic [ase_pkg::RF_DEPTH-1:0] vld;

  // Execute stage.
  logic        s1_valid;
  logic [31:0] s1_instr;
  logic        s1_go;
  logic        mode_hz;
  logic        in_acc;

  // Register file ports: Rn, Rm, Rs.
  logic [AW-1:0] ra_n, ra_m, ra_s;
  logic [31:0]   rd_n, rd_m, rd_s;
  logic          ovr_n, ovr_m, ovr_s;
  logic [31:0]   ovd_n, ovd_m, ovd_s;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;

  // Execute results.
  logic        x_exec, x_regw, x_pcw;
  logic [3:0]  x_dest;
  logic [31:0] x_wval, x_tgt, x_npc;
  logic [1:0]  x_stat;
  logic [31:0] cpsr_next, saved_svc_next, saved_irq_next;

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] d;
    d = {v, v} >> s;
    return d[31:0];
  endfunction

  function automatic logic cond_ok(input logic [3:0] cc, input logic [3:0] f);
    logic n, z, c, v, r;
    n = f[3];
    z = f[2];
    c = f[1];
    v = f[0];
    case (cc)
      4'd0:    r = z;
      4'd1:    r = !z;
      4'd2:    r = c;
      4'd3:    r = !c;
      4'd4:    r = n;
      4'd5:    r = !n;
      4'd6:    r = v;
      4'd7:    r = !v;
      4'd8:    r = c && !z;
      4'd9:    r = !c || z;
      4'd10:   r = (n == v);
      4'd11:   r = (n != v);
      4'd12:   r = !z && (n == v);
      4'd13:   r = z || (n != v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  // Barrel shifter: returns {carry out, operand 2}.
  function automatic logic [32:0] barrel(input logic [31:0] ins, input logic [31:0] v,
                                         input logic [31:0] rs, input logic cin);
    logic [31:0] r;
    logic        c;
    logic [7:0]  n;
    logic [4:0]  k;
    r = v;
    c = cin;
    n = rs[7:0];
    k = ins[11:7];
    if (ins[25]) begin
      r = ror32({24'd0, ins[7:0]}, {ins[11:8], 1'b0});
      c = (ins[11:8] != 4'd0) ? r[31] : cin;
    end else if (ins[4]) begin
      if (n != 8'd0) begin
        case (ins[6:5])
          2'd0: begin
            if (n < 8'd32) begin
              r = v << n[4:0];
              c = v[5'(6'd32 - {1'b0, n[4:0]})];
            end else begin
              r = 32'd0;
              c = (n == 8'd32) ? v[0] : 1'b0;
            end
          end
          2'd1: begin
            if (n < 8'd32) begin
              r = v >> n[4:0];
              c = v[5'(n[4:0] - 5'd1)];
            end else begin
              r = 32'd0;
              c = (n == 8'd32) ? v[31] : 1'b0;
            end
          end
          2'd2: begin
            if (n < 8'd32) begin
              r = 32'($signed(v) >>> n[4:0]);
              c = v[5'(n[4:0] - 5'd1)];
            end else begin
              r = {32{v[31]}};
              c = v[31];
            end
          end
          default: begin
            if (n[4:0] == 5'd0) begin
              c = v[31];
            end else begin
              r = ror32(v, n[4:0]);
              c = v[5'(n[4:0] - 5'd1)];
            end
          end
        endcase
      end
    end else begin
      case (ins[6:5])
        2'd0: begin
          if (k != 5'd0) begin
            r = v << k;
            c = v[5'(6'd32 - {1'b0, k})];
          end
        end
        2'd1: begin
          if (k == 5'd0) begin
            r = 32'd0;
            c = v[31];
          end else begin
            r = v >> k;
            c = v[5'(k - 5'd1)];
          end
        end
        2'd2: begin
          if (k == 5'd0) begin
            r = {32{v[31]}};
            c = v[31];
          end else begin
            r = 32'($signed(v) >>> k);
            c = v[5'(k - 5'd1)];
          end
        end
        default: begin
          if (k == 5'd0) begin
            r = {cin, v[31:1]};
            c = v[0];
          end else begin
            r = ror32(v, k);
            c = v[5'(k - 5'd1)];
          end
        end
      endcase
    end
    return {c, r};
  endfunction

  // ---------------------------------------------------------------- handshake
  assign s1_go  = s1_valid && (!out_valid || out_ready);
  // Hold off the next read while the item in execute may switch the register bank.
  assign mode_hz = (s1_instr[27:26] == ase_pkg::CLS_DP) && (s1_instr[25] || !s1_instr[7]) &&
                   ((s1_instr[20] && (s1_instr[15:12] == ase_pkg::REG_PC)) ||
                    (!s1_instr[20] && (s1_instr[24:23] == 2'b10) && s1_instr[21]));
  assign in_ready = !s1_valid || (s1_go && !mode_hz);
  assign in_acc   = in_valid && in_ready;

  // ---------------------------------------------------------------- register file
  assign ra_n = ase_pkg::phys_addr(instr_word[19:16], cpsr[3:0]);
  assign ra_m = ase_pkg::phys_addr(instr_word[3:0], cpsr[3:0]);
  assign ra_s = ase_pkg::phys_addr(instr_word[11:8], cpsr[3:0]);

  assign ram_we    = s1_go && x_regw && (x_dest != ase_pkg::REG_PC);
  assign ram_waddr = ase_pkg::phys_addr(x_dest, cpsr[3:0]);
  assign ram_wdata = x_wval;

  ase_ram #(.WIDTH(32), .DEPTH(ase_pkg::RF_DEPTH)) u_rf_n (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(in_acc), .raddr(ra_n), .rdata(rd_n)
  );
  ase_ram #(.WIDTH(32), .DEPTH(ase_pkg::RF_DEPTH)) u_rf_m (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(in_acc), .raddr(ra_m), .rdata(rd_m)
  );
  ase_ram #(.WIDTH(32), .DEPTH(ase_pkg::RF_DEPTH)) u_rf_s (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(in_acc), .raddr(ra_s), .rdata(rd_s)
  );

  // Forward a write landing on the read edge, or supply the reset value of an
  // unwritten slot.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ovr_n <= (ram_we && (ram_waddr == ra_n)) || !vld[ra_n];
      ovr_m <= (ram_we && (ram_waddr == ra_m)) || !vld[ra_m];
      ovr_s <= (ram_we && (ram_waddr == ra_s)) || !vld[ra_s];
      ovd_n <= (ram_we && (ram_waddr == ra_n)) ? ram_wdata :
               ase_pkg::rf_reset_val(ra_n, direct_boot);
      ovd_m <= (ram_we && (ram_waddr == ra_m)) ? ram_wdata :
               ase_pkg::rf_reset_val(ra_m, direct_boot);
      ovd_s <= (ram_we && (ram_waddr == ra_s)) ? ram_wdata :
               ase_pkg::rf_reset_val(ra_s, direct_boot);
    end
  end

  // ---------------------------------------------------------------- execute
  always_comb begin
    logic [31:0] ins, rn_v, rm_v, rs_v, op1, op2, a, b, r, spsr_cur, val, off;
    logic [32:0] sh, sum;
    logic [3:0]  mode, rd;
    logic        bank_ok, cin, ci, arith, wr, ovf;
    logic [5:0]  sel;

    ins      = s1_instr;
    mode     = cpsr[3:0];
    bank_ok  = (mode == ase_pkg::MODE_SVC) || (mode == ase_pkg::MODE_IRQ);
    spsr_cur = (mode == ase_pkg::MODE_IRQ) ? saved_irq : saved_svc;
    cin      = cpsr[29];
    rd       = ins[15:12];
    sel      = ins[21:16];

    rn_v = ovr_n ? ovd_n : rd_n;
    rm_v = ovr_m ? ovd_m : rd_m;
    rs_v = ovr_s ? ovd_s : rd_s;
    if (ins[19:16] == ase_pkg::REG_PC) begin
      rn_v = pc + ((!ins[25] && ins[4]) ? 32'd12 : 32'd8);
    end
    if (ins[11:8] == ase_pkg::REG_PC) begin
      rs_v = pc + 32'd8;
    end
    op1 = rn_v;
    // Rm of a register-shifted data-processing op sees PC + 12; BX sees PC + 8.
    if (ins[3:0] == ase_pkg::REG_PC) begin
      rm_v = pc + ((!ins[25] && ins[4] && (ins[27:26] == ase_pkg::CLS_DP) &&
                    ((ins & ase_pkg::BX_MASK) != ase_pkg::BX_PATTERN)) ? 32'd12 : 32'd8);
    end

    sh  = barrel(ins, rm_v, rs_v, cin);
    op2 = sh[31:0];
    a   = op1;
    b   = op2;
    ci  = 1'b0;
    case (ase_pkg::alu_op_t'(ins[24:21]))
      ase_pkg::OP_SUB, ase_pkg::OP_CMP: begin b = ~op2; ci = 1'b1; end
      ase_pkg::OP_RSB:                  begin a = op2; b = ~op1; ci = 1'b1; end
      ase_pkg::OP_ADC:                  begin ci = cin; end
      ase_pkg::OP_SBC:                  begin b = ~op2; ci = cin; end
      ase_pkg::OP_RSC:                  begin a = op2; b = ~op1; ci = cin; end
      default:                          begin ci = 1'b0; end
    endcase
    sum = {1'b0, a} + {1'b0, b} + {32'd0, ci};
    ovf = ((a[31] ^ sum[31]) & (b[31] ^ sum[31]));

    arith = 1'b1;
    wr    = 1'b1;
    case (ase_pkg::alu_op_t'(ins[24:21]))
      ase_pkg::OP_AND:  begin r = op1 & op2; arith = 1'b0; end
      ase_pkg::OP_EOR:  begin r = op1 ^ op2; arith = 1'b0; end
      ase_pkg::OP_TST:  begin r = op1 & op2; arith = 1'b0; wr = 1'b0; end
      ase_pkg::OP_TEQ:  begin r = op1 ^ op2; arith = 1'b0; wr = 1'b0; end
      ase_pkg::OP_CMP,
      ase_pkg::OP_CMN:  begin r = sum[31:0]; wr = 1'b0; end
      ase_pkg::OP_ORR:  begin r = op1 | op2; arith = 1'b0; end
      ase_pkg::OP_MOV:  begin r = op2; arith = 1'b0; end
      ase_pkg::OP_BIC:  begin r = op1 & ~op2; arith = 1'b0; end
      ase_pkg::OP_MVN:  begin r = ~op2; arith = 1'b0; end
      default:          begin r = sum[31:0]; end
    endcase

    off = {{6{ins[23]}}, ins[23:0], 2'b00};
    val = 32'd0;

    x_exec         = 1'b0;
    x_regw         = 1'b0;
    x_dest         = 4'd0;
    x_wval         = 32'd0;
    x_pcw          = 1'b0;
    x_tgt          = 32'd0;
    x_stat         = ase_pkg::ST_OK;
    cpsr_next      = cpsr;
    saved_svc_next = saved_svc;
    saved_irq_next = saved_irq;

    if (cpsr[ase_pkg::T_BIT]) begin
      x_stat = ase_pkg::ST_UNSUP;
    end else if (cond_ok(ins[31:28], cpsr[31:28])) begin
      x_exec = 1'b1;
      if ((ins[27:26] == ase_pkg::CLS_DP) &&
          ((ins & ase_pkg::BX_MASK) == ase_pkg::BX_PATTERN)) begin
        // BX: T from bit 0 of the target.
        cpsr_next[ase_pkg::T_BIT] = rm_v[0];
        x_pcw = 1'b1;
        x_tgt = rm_v;
      end else if ((ins[27:26] == ase_pkg::CLS_DP) && (ins[25] || !ins[7])) begin
        if (!ins[20] && (ins[24:23] == 2'b10)) begin
          // PSR transfer; rejected patterns leave no trace.
          x_exec = 1'b0;
          x_stat = ase_pkg::ST_PSR;
          if (sel == ase_pkg::PSR_MRS) begin
            if ((rd != ase_pkg::REG_PC) && (!ins[22] || bank_ok)) begin
              x_regw = 1'b1;
              x_dest = rd;
              x_wval = ins[22] ? spsr_cur : cpsr;
              x_exec = 1'b1;
              x_stat = ase_pkg::ST_OK;
            end
          end else if ((sel == ase_pkg::PSR_MSR_ALL) || (sel == ase_pkg::PSR_MSR_FLG)) begin
            if ((((sel == ase_pkg::PSR_MSR_FLG) && ins[25]) ||
                 (ins[3:0] != ase_pkg::REG_PC)) && (!ins[22] || bank_ok)) begin
              x_exec = 1'b1;
              x_stat = ase_pkg::ST_OK;
              if (sel == ase_pkg::PSR_MSR_ALL) begin
                val = rm_v;
              end else begin
                val = ins[25] ? ror32({24'd0, ins[7:0]}, {ins[11:8], 1'b0}) : rm_v;
              end
              if (!ins[22]) begin
                cpsr_next = (sel == ase_pkg::PSR_MSR_ALL) ? val :
                            ((cpsr & ~ase_pkg::FLAG_MASK) | (val & ase_pkg::FLAG_MASK));
              end else if (mode == ase_pkg::MODE_IRQ) begin
                saved_irq_next = (sel == ase_pkg::PSR_MSR_ALL) ? val :
                                 ((saved_irq & ~ase_pkg::FLAG_MASK) |
                                  (val & ase_pkg::FLAG_MASK));
              end else begin
                saved_svc_next = (sel == ase_pkg::PSR_MSR_ALL) ? val :
                                 ((saved_svc & ~ase_pkg::FLAG_MASK) |
                                  (val & ase_pkg::FLAG_MASK));
              end
            end
          end
        end else begin
          if (wr) begin
            x_regw = 1'b1;
            x_dest = rd;
            x_wval = r;
            if (rd == ase_pkg::REG_PC) begin
              x_pcw = 1'b1;
              x_tgt = r;
            end
          end
          if (ins[20]) begin
            cpsr_next[31] = r[31];
            cpsr_next[30] = (r == 32'd0);
            if (arith) begin
              cpsr_next[29] = sum[32];
              cpsr_next[28] = ovf;
            end else begin
              cpsr_next[29] = sh[32];
            end
            if (rd == ase_pkg::REG_PC) begin
              if (bank_ok) begin
                cpsr_next = spsr_cur;
              end else begin
                x_stat = ase_pkg::ST_PSR;
              end
            end
          end
        end
      end else if (ins[27:26] == ase_pkg::CLS_DP) begin
        x_exec = 1'b0;
        x_stat = ((ins[6:5] == 2'b00) && (ins[24:23] == 2'b11)) ?
                 ase_pkg::ST_UNDEF : ase_pkg::ST_UNSUP;
      end else if (ins[27:26] == ase_pkg::CLS_LS) begin
        x_exec = 1'b0;
        x_stat = (ins[25] && ins[4]) ? ase_pkg::ST_UNDEF : ase_pkg::ST_UNSUP;
      end else if (ins[27:26] == ase_pkg::CLS_BR) begin
        if (ins[25]) begin
          if (ins[24]) begin
            x_regw = 1'b1;
            x_dest = ase_pkg::REG_LR;
            x_wval = pc + 32'd4;
          end
          x_pcw = 1'b1;
          x_tgt = pc + 32'd8 + off;
        end else begin
          x_exec = 1'b0;
          x_stat = ase_pkg::ST_UNSUP;
        end
      end else begin
        x_exec = 1'b0;
        x_stat = (ins[27:24] == 4'hF) ? ase_pkg::ST_UNSUP : ase_pkg::ST_UNDEF;
      end
    end

    // Next fetch: halfword step in Thumb state, else redirect or word step.
    if (cpsr[ase_pkg::T_BIT]) begin
      x_npc = pc + 32'd2;
    end else if (x_pcw) begin
      x_npc = cpsr_next[ase_pkg::T_BIT] ? {x_tgt[31:1], 1'b0} : {x_tgt[31:2], 2'b00};
    end else begin
      x_npc = pc + 32'd4;
    end
  end

  // ---------------------------------------------------------------- state update
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      direct_boot <= rst ? 1'b0 : cfg_wr_data;
      pc          <= (!rst && cfg_wr_data) ? ase_pkg::BOOT_PC : 32'd0;
      cpsr        <= (!rst && cfg_wr_data) ? ase_pkg::CPSR_BOOT : ase_pkg::CPSR_COLD;
      saved_svc   <= 32'd0;
      saved_irq   <= 32'd0;
      vld         <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
        pc        <= x_npc;
        cpsr      <= cpsr_next;
        saved_svc <= saved_svc_next;
        saved_irq <= saved_irq_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_instr <= instr_word;
    end
    if (s1_go) begin
      executed        <= x_exec;
      reg_written     <= x_regw;
      dest_index      <= x_dest;
      write_value     <= x_wval;
      branch_taken    <= x_pcw;
      next_fetch_addr <= x_npc;
      thumb_state     <= cpsr_next[ase_pkg::T_BIT];
      flags_nzcv      <= cpsr_next[31:28];
      status          <= x_stat;
    end
  end

  // ---------------------------------------------------------------- checks
  a_s1_hold: assert property (@(posedge clk) disable iff (rst || cfg_wr_en)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_instr))
    else $error("execute stage lost a stalled item");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst || cfg_wr_en)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted item did not reach execute");

  a_no_pc_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ram_waddr != AW'(ase_pkg::REG_PC))
    else $error("register file write to PC slot");

  a_exec_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && executed |-> (status == ase_pkg::ST_OK) || (status == ase_pkg::ST_PSR))
    else $error("executed item with unsupported status");

  a_hz_block: assert property (@(posedge clk) disable iff (rst)
    s1_valid && mode_hz |-> !in_ready)
    else $error("accept while bank may switch");

endmodule

// ===== tb/arm_state_execute_unit_tb.sv =====
// Self-checking testbench for the ARM-state execute unit with a built-in predictor.
module arm_state_execute_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ase_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 150;
  localparam int NUM_PHASES   = 6;
  localparam int MAX_GAP      = 13;

  typedef struct packed {
    logic        executed;
    logic        reg_written;
    logic [3:0]  dest_index;
    logic [31:0] write_value;
    logic        branch_taken;
    logic [31:0] next_fetch_addr;
    logic        thumb_state;
    logic [3:0]  flags_nzcv;
    logic [1:0]  status;
  } exec_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instr_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        executed, reg_written, branch_taken, thumb_state;
  logic [3:0]  dest_index, flags_nzcv;
  logic [31:0] write_value, next_fetch_addr;
  logic [1:0]  status;

  arm_state_execute_unit i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .instr_word(instr_word),
    .out_valid(out_valid), .out_ready(out_ready), .executed(executed),
    .reg_written(reg_written), .dest_index(dest_index), .write_value(write_value),
    .branch_taken(branch_taken), .next_fetch_addr(next_fetch_addr),
    .thumb_state(thumb_state), .flags_nzcv(flags_nzcv), .status(status)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: architectural registers as the block should hold them
  // ---------------------------------------------------------------------------
  logic [31:0] gpr [16];
  logic [31:0] bank_regs [4];   // svc R13, svc R14, irq R13, irq R14
  logic [31:0] spsr_q [2];      // svc, irq
  logic [31:0] cpsr;
  logic        boot_mode = 1'b0;
  logic        pc_wr;

  logic [31:0] instr_queue [$];
  exec_res_t   expected_results [$];
  int          errors = 0;
  int          cycles = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  logic        burst = 1'b0;

  // Reload every register with its reset value for the current boot mode.
  function automatic void load_reset_state();
    for (int i = 0; i < 16; i++) gpr[i] = '0;
    for (int i = 0; i < 4; i++) bank_regs[i] = '0;
    spsr_q[0] = '0;
    spsr_q[1] = '0;
    cpsr = CPSR_COLD;
    if (boot_mode) begin
      gpr[13] = BOOT_SP;
      gpr[15] = BOOT_PC;
      bank_regs[0] = BOOT_SP_SVC;
      bank_regs[2] = BOOT_SP_IRQ;
      cpsr = CPSR_BOOT;
    end
    pc_wr = 1'b0;
  endfunction

  function automatic int bank_of();
    if (cpsr[3:0] == MODE_SVC) return 0;
    if (cpsr[3:0] == MODE_IRQ) return 1;
    return -1;
  endfunction

  function automatic logic [31:0] read_reg(input logic [3:0] idx, input logic [31:0] pc_off);
    int b;
    b = bank_of();
    if (idx == REG_PC) return gpr[15] + pc_off;
    if ((idx == REG_SP || idx == REG_LR) && b >= 0) return bank_regs[b * 2 + int'(idx) - 13];
    return gpr[idx];
  endfunction

  function automatic void write_reg(input logic [3:0] idx, input logic [31:0] val);
    int b;
    b = bank_of();
    if ((idx == REG_SP || idx == REG_LR) && b >= 0) begin
      bank_regs[b * 2 + int'(idx) - 13] = val;
      return;
    end
    gpr[idx] = val;
    if (idx == REG_PC) pc_wr = 1'b1;
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    n = n & 31;
    if (n == 0) return v;
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] rot_imm(input logic [31:0] ins);
    return ror32({24'd0, ins[7:0]}, int'(ins[11:8]) * 2);
  endfunction

  // Barrel shifter: second operand and its carry out
  function automatic logic [31:0] shift_operand(input logic [31:0] ins, input logic cin,
                                                output logic cout);
    logic [31:0] v;
    int n;
    logic [1:0] kind;
    kind = ins[6:5];
    if (ins[25]) begin
      v = rot_imm(ins);
      cout = (ins[11:8] != 0) ? v[31] : cin;
      return v;
    end
    if (ins[4]) begin
      v = read_reg(ins[3:0], 32'd12);
      n = int'(read_reg(ins[11:8], 32'd8) & 32'hFF);
      cout = cin;
      if (n == 0) return v;
      case (kind)
        2'd0: begin
          if (n < 32) begin cout = v[32 - n]; return v << n; end
          cout = (n == 32) ? v[0] : 1'b0;
          return '0;
        end
        2'd1: begin
          if (n < 32) begin cout = v[n - 1]; return v >> n; end
          cout = (n == 32) ? v[31] : 1'b0;
          return '0;
        end
        2'd2: begin
          if (n < 32) begin cout = v[n - 1]; return $signed(v) >>> n; end
          cout = v[31];
          return {32{v[31]}};
        end
        default: begin
          if ((n & 31) == 0) begin cout = v[31]; return v; end
          cout = v[(n - 1) & 31];
          return ror32(v, n);
        end
      endcase
    end
    v = read_reg(ins[3:0], 32'd8);
    n = int'(ins[11:7]);
    case (kind)
      2'd0: begin
        if (n == 0) begin cout = cin; return v; end
        cout = v[32 - n];
        return v << n;
      end
      2'd1: begin
        if (n == 0) begin cout = v[31]; return '0; end
        cout = v[n - 1];
        return v >> n;
      end
      2'd2: begin
        if (n == 0) begin cout = v[31]; return {32{v[31]}}; end
        cout = v[n - 1];
        return $signed(v) >>> n;
      end
      default: begin
        if (n == 0) begin cout = v[0]; return {cin, v[31:1]}; end
        cout = v[n - 1];
        return ror32(v, n);
      end
    endcase
  endfunction

  // Sum with carry and overflow, packed as {v, c, sum}.
  function automatic logic [33:0] add_cv(input logic [31:0] a, input logic [31:0] b,
                                         input logic cin);
    logic [32:0] s;
    logic ov;
    s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    ov = ((a[31] ^ s[31]) & (b[31] ^ s[31]));
    return {ov, s};
  endfunction

  function automatic logic cond_pass(input logic [3:0] cc);
    logic n, z, c, v;
    {n, z, c, v} = cpsr[31:28];
    case (cc)
      4'd0:  return z;
      4'd1:  return !z;
      4'd2:  return c;
      4'd3:  return !c;
      4'd4:  return n;
      4'd5:  return !n;
      4'd6:  return v;
      4'd7:  return !v;
      4'd8:  return c && !z;
      4'd9:  return !c || z;
      4'd10: return n == v;
      4'd11: return n != v;
      4'd12: return !z && (n == v);
      4'd13: return z || (n != v);
      default: return 1'b1;
    endcase
  endfunction

  // Execute one instruction on the predictor state and return the expected result.
  function automatic exec_res_t execute_instr(input logic [31:0] ins);
    exec_res_t   res;
    logic [31:0] pc, val, op1, op2, r, f, off, pc_off;
    logic [33:0] sum;
    logic        cin, sc, c, v, arith, wr, use_spsr, imm;
    logic [3:0]  rd;
    logic [5:0]  sel;
    alu_op_t     op;
    status_t     st;
    int          b;
    res = '0;
    st = ST_OK;
    pc = gpr[15];
    b = bank_of();
    pc_wr = 1'b0;
    if (cpsr[T_BIT]) begin
      st = ST_UNSUP;
      gpr[15] = pc + 32'd2;
    end else if (cond_pass(ins[31:28])) begin
      res.executed = 1'b1;
      if (iclass_t'(ins[27:26]) == CLS_DP && (ins & BX_MASK) == BX_PATTERN) begin
        val = read_reg(ins[3:0], 32'd8);
        cpsr[T_BIT] = val[0];
        write_reg(REG_PC, val);
      end else if (iclass_t'(ins[27:26]) == CLS_DP && (ins[25] || !ins[7])) begin
        op = alu_op_t'(ins[24:21]);
        rd = ins[15:12];
        if (!ins[20] && ins[24:23] == 2'b10) begin
          // status register transfer
          sel = ins[21:16];
          use_spsr = ins[22];
          res.executed = 1'b0;
          st = ST_PSR;
          if (sel == PSR_MRS) begin
            if (rd != REG_PC && (!use_spsr || b >= 0)) begin
              val = use_spsr ? spsr_q[b] : cpsr;
              write_reg(rd, val);
              res.reg_written = 1'b1;
              res.dest_index = rd;
              res.write_value = val;
              res.executed = 1'b1;
              st = ST_OK;
            end
          end else if (sel == PSR_MSR_ALL) begin
            if (ins[3:0] != REG_PC && (!use_spsr || b >= 0)) begin
              val = read_reg(ins[3:0], 32'd8);
              if (use_spsr) spsr_q[b] = val; else cpsr = val;
              res.executed = 1'b1;
              st = ST_OK;
            end
          end else if (sel == PSR_MSR_FLG) begin
            imm = ins[25];
            if ((imm || ins[3:0] != REG_PC) && (!use_spsr || b >= 0)) begin
              val = (imm ? rot_imm(ins) : read_reg(ins[3:0], 32'd8)) & FLAG_MASK;
              if (use_spsr) spsr_q[b] = (spsr_q[b] & ~FLAG_MASK) | val;
              else cpsr = (cpsr & ~FLAG_MASK) | val;
              res.executed = 1'b1;
              st = ST_OK;
            end
          end
        end else begin
          cin = cpsr[29];
          c = 1'b0;
          v = 1'b0;
          pc_off = (!ins[25] && ins[4]) ? 32'd12 : 32'd8;
          op2 = shift_operand(ins, cin, sc);
          op1 = read_reg(ins[19:16], pc_off);
          arith = 1'b1;
          wr = 1'b1;
          sum = '0;
          case (op)
            OP_AND: begin r = op1 & op2; arith = 1'b0; end
            OP_EOR: begin r = op1 ^ op2; arith = 1'b0; end
            OP_SUB: sum = add_cv(op1, ~op2, 1'b1);
            OP_RSB: sum = add_cv(op2, ~op1, 1'b1);
            OP_ADD: sum = add_cv(op1, op2, 1'b0);
            OP_ADC: sum = add_cv(op1, op2, cin);
            OP_SBC: sum = add_cv(op1, ~op2, cin);
            OP_RSC: sum = add_cv(op2, ~op1, cin);
            OP_TST: begin r = op1 & op2; arith = 1'b0; wr = 1'b0; end
            OP_TEQ: begin r = op1 ^ op2; arith = 1'b0; wr = 1'b0; end
            OP_CMP: begin sum = add_cv(op1, ~op2, 1'b1); wr = 1'b0; end
            OP_CMN: begin sum = add_cv(op1, op2, 1'b0); wr = 1'b0; end
            OP_ORR: begin r = op1 | op2; arith = 1'b0; end
            OP_MOV: begin r = op2; arith = 1'b0; end
            OP_BIC: begin r = op1 & ~op2; arith = 1'b0; end
            default: begin r = ~op2; arith = 1'b0; end
          endcase
          if (arith) {v, c, r} = sum;
          if (wr) begin
            write_reg(rd, r);
            res.reg_written = 1'b1;
            res.dest_index = rd;
            res.write_value = r;
          end
          if (ins[20]) begin
            f = cpsr;
            f[31] = r[31];
            f[30] = (r == 0);
            if (arith) begin
              f[29] = c;
              f[28] = v;
            end else begin
              f[29] = sc;
            end
            cpsr = f;
            // S with Rd = PC restores the saved status where the mode has one
            if (rd == REG_PC) begin
              if (b >= 0) cpsr = spsr_q[b];
              else st = ST_PSR;
            end
          end
        end
      end else if (iclass_t'(ins[27:26]) == CLS_DP) begin
        res.executed = 1'b0;
        st = (ins[6:5] == 2'b00 && ins[24:23] == 2'b11) ? ST_UNDEF : ST_UNSUP;
      end else if (iclass_t'(ins[27:26]) == CLS_LS) begin
        res.executed = 1'b0;
        st = (ins[25] && ins[4]) ? ST_UNDEF : ST_UNSUP;
      end else if (iclass_t'(ins[27:26]) == CLS_BR) begin
        if (ins[25]) begin
          off = {{6{ins[23]}}, ins[23:0], 2'b00};
          if (ins[24]) begin
            write_reg(REG_LR, pc + 32'd4);
            res.reg_written = 1'b1;
            res.dest_index = REG_LR;
            res.write_value = pc + 32'd4;
          end
          write_reg(REG_PC, pc + 32'd8 + off);
        end else begin
          res.executed = 1'b0;
          st = ST_UNSUP;
        end
      end else begin
        res.executed = 1'b0;
        st = (ins[27:24] == 4'hF) ? ST_UNSUP : ST_UNDEF;
      end
    end

    // Advance or align the program counter
    if (!cpsr[T_BIT] || st != ST_UNSUP || res.executed) begin
      if (pc_wr)
        gpr[15] = gpr[15] & (cpsr[T_BIT] ? 32'hFFFF_FFFE : 32'hFFFF_FFFC);
      else if (gpr[15] == pc &&
               !(st == ST_UNSUP && !res.executed && pc + 32'd2 == gpr[15]))
        gpr[15] = pc + 32'd4;
    end

    res.branch_taken = pc_wr;
    res.next_fetch_addr = gpr[15];
    res.thumb_state = cpsr[T_BIT];
    res.flags_nzcv = cpsr[31:28];
    res.status = st;
    return res;
  endfunction

  // Random instruction, weighted toward well-formed classes so deep paths are reached.
  function automatic logic [31:0] random_instr();
    logic [3:0]  cc;
    logic [31:0] w;
    int          pick;
    cc = ($urandom_range(0, 99) < 70) ? 4'hE : 4'($urandom);
    pick = $urandom_range(0, 99);
    w = $urandom;
    if (pick < 50) begin
      w[27:26] = CLS_DP;
      if (!w[25] && w[4]) w[7] = 1'b0;
      if ($urandom_range(0, 9) != 0) w[15:12] = 4'($urandom_range(0, 14));
    end else if (pick < 60) begin
      w[27:25] = 3'b101;
    end else if (pick < 62) begin
      w[27:4] = 24'h12FFF1;
    end else if (pick < 74) begin
      case ($urandom_range(0, 2))
        0: w = {4'h0, 5'b00010, w[22], PSR_MRS, w[15:12], 12'h000};
        1: w = {4'h0, 5'b00010, w[22], PSR_MSR_ALL, 4'hF, 8'h00, w[3:0]};
        default: w = {4'h0, 2'b00, w[25], 2'b10, w[22], PSR_MSR_FLG, 4'hF, w[11:0]};
      endcase
    end
    w[31:28] = cc;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued items with random gaps, hold each until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic        nxt_valid;
    logic [31:0] nxt_word;
    nxt_valid = in_valid;
    nxt_word = instr_word;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || in_taken) begin
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (instr_queue.size() > 0) begin
        nxt_valid = 1'b1;
        nxt_word = instr_queue.pop_front();
        if ($urandom_range(0, 39) == 0) burst <= ~burst;
        in_gap <= burst ? 0 : $urandom_range(0, MAX_GAP);
      end
    end
    in_valid <= nxt_valid;
    instr_word <= nxt_word;
  end

  // Result side: hold out_ready low for a random stall after each taken item, none in a burst
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (out_taken) out_stall <= burst ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h", cycles, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted item, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    exec_res_t want;
    in_taken <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (in_valid && in_ready) expected_results.push_back(execute_instr(instr_word));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", 32'd1, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (executed !== want.executed)
            report_mismatch("executed", 32'(executed), 32'(want.executed));
          if (reg_written !== want.reg_written)
            report_mismatch("reg_written", 32'(reg_written), 32'(want.reg_written));
          if (dest_index !== want.dest_index)
            report_mismatch("dest_index", 32'(dest_index), 32'(want.dest_index));
          if (write_value !== want.write_value)
            report_mismatch("write_value", write_value, want.write_value);
          if (branch_taken !== want.branch_taken)
            report_mismatch("branch_taken", 32'(branch_taken), 32'(want.branch_taken));
          if (next_fetch_addr !== want.next_fetch_addr)
            report_mismatch("next_fetch_addr", next_fetch_addr, want.next_fetch_addr);
          if (thumb_state !== want.thumb_state)
            report_mismatch("thumb_state", 32'(thumb_state), 32'(want.thumb_state));
          if (flags_nzcv !== want.flags_nzcv)
            report_mismatch("flags_nzcv", 32'(flags_nzcv), 32'(want.flags_nzcv));
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
        end
      end
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Wait until every queued item has been sent and every result checked.
  task automatic drain();
    while (instr_queue.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write direct_boot while idle; the write reloads all state on both sides.
  task automatic write_boot(input logic val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    boot_mode = val;
    load_reset_state();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    load_reset_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every opcode with S set, shift corner cases, branches, PSR access
    for (int op = 0; op < 16; op++)
      instr_queue.push_back({4'hE, 3'b001, 4'(op), 1'b1, 4'd1, 4'd2, 12'h4FF});
    instr_queue.push_back({4'hE, 3'b001, OP_MOV, 1'b1, 4'd0, 4'd3, 12'h2FF}); // rotated imm
    instr_queue.push_back({4'hE, 3'b000, OP_MOV, 1'b1, 4'd0, 4'd4, 5'd0, 2'b01, 1'b0, 4'd3});
    instr_queue.push_back({4'hE, 3'b000, OP_MOV, 1'b1, 4'd0, 4'd5, 5'd0, 2'b11, 1'b0, 4'd3});
    instr_queue.push_back({4'hE, 3'b000, OP_ADD, 1'b1, 4'hF, 4'd6, 4'hF, 1'b0, 2'b10, 1'b1,
                           4'hF});                                   // register shift by PC
    instr_queue.push_back({4'h0, 3'b001, OP_MOV, 1'b0, 4'd0, 4'd7, 12'h001}); // may fail cond
    instr_queue.push_back({4'hF, 3'b101, 1'b1, 24'hFFFFFE});                  // BL backwards
    instr_queue.push_back({4'hE, 5'b00010, 1'b0, PSR_MRS, 4'd8, 12'h000});
    instr_queue.push_back({4'hE, 5'b00110, 1'b0, PSR_MSR_FLG, 4'hF, 12'h4F0});
    instr_queue.push_back({4'hE, 5'b00010, 1'b1, PSR_MRS, 4'd9, 12'h000}); // saved status
    instr_queue.push_back({4'hE, 24'h12FFF1, 4'd3});                      // BX to odd address
    instr_queue.push_back({4'hE, 3'b001, OP_MOV, 1'b0, 4'd0, 4'd1, 12'h001}); // in Thumb state
    drain();

    // Random phases, each preceded by a boot-mode write (both extremes, several times)
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_boot(ph[0] ? 1'b0 : 1'b1);
      for (int i = 0; i < PHASE_ITEMS; i++) instr_queue.push_back(random_instr());
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== arm_state_execute_unit.f =====
rtl/ase_pkg.sv
rtl/ase_ram.sv
rtl/arm_state_execute_unit.sv
tb/arm_state_execute_unit_tb.sv
